/* hdl/serial_bank_switch_mapper_defines.svh */
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_defines
// Assertion macros for the serial bank-switch mapper.
// Clock aclk and reset aresetn are taken from the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BANK_SWITCH_MAPPER_DEFINES_SVH
`define SERIAL_BANK_SWITCH_MAPPER_DEFINES_SVH

// Same-cycle implication.
`define SBSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbsm: same-cycle check failed");

// Next-cycle implication.
`define SBSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbsm: next-cycle check failed");

`endif

/* hdl/sbsm_pkg.sv */
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types and constants shared by the serial bank-switch mapper modules.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    typedef enum logic {
        OP_BUS_WRITE = 1'b0,
        OP_INSN_DONE = 1'b1
    } sbsm_op_t;

    localparam int LAST_PRG_BANK = 15;

    typedef struct packed {
        sbsm_op_t    op;
        logic [15:0] address;
        logic [7:0]  value;
    } sbsm_item_t;

    typedef struct packed {
        logic [17:0] prg_offset_low;
        logic [17:0] prg_offset_high;
        logic [4:0]  control_value;
        logic [4:0]  chr_bank_low;
        logic [4:0]  chr_bank_high;
        logic [4:0]  prg_bank;
    } sbsm_result_t;

endpackage

/* hdl/sbsm_in_stage.sv */
// ----------------------------------------------------------------------------
// sbsm_in_stage
// Input request register with valid/ready handshake.
// ----------------------------------------------------------------------------
module sbsm_in_stage
    import sbsm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sbsm_item_t s_item,
    input  logic       take,
    output logic       item_valid,
    output sbsm_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    sbsm_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/sbsm_core.sv */
// ----------------------------------------------------------------------------
// sbsm_core
// Serial shift register, bank registers and PRG offset update.
// ----------------------------------------------------------------------------
`include "serial_bank_switch_mapper_defines.svh"

module sbsm_core
    import sbsm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  sbsm_item_t   item,
    output sbsm_result_t result
);

    localparam logic [4:0]  SHIFT_EMPTY      = 5'h10;
    localparam logic [4:0]  CONTROL_RESET    = 5'h06;
    localparam logic [2:0]  BITS_PER_LOAD    = 3'd5;
    localparam logic [15:0] ADDR_CHR_LOW     = 16'hA000;
    localparam logic [15:0] ADDR_CHR_HIGH    = 16'hC000;
    localparam logic [15:0] ADDR_PRG         = 16'hE000;
    localparam logic [17:0] BANK_BYTES       = 18'h04000;
    localparam logic [17:0] LAST_BANK_OFFSET = 18'(LAST_PRG_BANK * 16'h4000);

    localparam logic [1:0] MODE_32K_A        = 2'd0;
    localparam logic [1:0] MODE_32K_B        = 2'd1;
    localparam logic [1:0] MODE_FIXED_FIRST  = 2'd2;

    logic [4:0]  shift_value_reg, shift_value_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic        write_blocked_reg, write_blocked_next;
    logic [4:0]  control_reg, control_next;
    logic [4:0]  chr_low_reg, chr_low_next;
    logic [4:0]  chr_high_reg, chr_high_next;
    logic [4:0]  prg_reg, prg_next;
    logic [17:0] offset_low_reg, offset_low_next;
    logic [17:0] offset_high_reg, offset_high_next;

    logic [4:0] shifted;
    logic [2:0] count_inc;
    logic       map_load;

    assign shifted   = {item.value[0], shift_value_reg[4:1]};
    assign count_inc = bit_count_reg + 3'd1;

    always_comb begin
        shift_value_next   = shift_value_reg;
        bit_count_next     = bit_count_reg;
        write_blocked_next = write_blocked_reg;
        control_next       = control_reg;
        chr_low_next       = chr_low_reg;
        chr_high_next      = chr_high_reg;
        prg_next           = prg_reg;
        map_load           = 1'b0;
        if (adv) begin
            if (item.op == OP_INSN_DONE) begin
                write_blocked_next = 1'b0;
            end else if (!write_blocked_reg) begin
                write_blocked_next = 1'b1;
                if (item.value[7]) begin
                    shift_value_next = SHIFT_EMPTY;
                    bit_count_next   = 3'd0;
                end else if (count_inc == BITS_PER_LOAD) begin
                    if (item.address < ADDR_CHR_LOW) begin
                        control_next = shifted;
                        map_load     = 1'b1;
                    end else if (item.address < ADDR_CHR_HIGH) begin
                        chr_low_next = shifted;
                    end else if (item.address < ADDR_PRG) begin
                        chr_high_next = shifted;
                    end else begin
                        prg_next = shifted;
                        map_load = 1'b1;
                    end
                    shift_value_next = SHIFT_EMPTY;
                    bit_count_next   = 3'd0;
                end else begin
                    shift_value_next = shifted;
                    bit_count_next   = count_inc;
                end
            end
        end
    end

    // PRG offsets from the updated control and PRG registers
    always_comb begin
        offset_low_next  = offset_low_reg;
        offset_high_next = offset_high_reg;
        if (map_load) begin
            case (control_next[3:2])
                MODE_32K_A, MODE_32K_B: begin
                    offset_low_next  = {prg_next[3:1], 1'b0, 14'd0};
                    offset_high_next = {prg_next[3:1], 1'b0, 14'd0} + BANK_BYTES;
                end
                MODE_FIXED_FIRST: begin
                    offset_low_next  = 18'd0;
                    offset_high_next = {prg_next[3:0], 14'd0};
                end
                default: begin
                    offset_low_next  = {prg_next[3:0], 14'd0};
                    offset_high_next = LAST_BANK_OFFSET;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_value_reg   <= SHIFT_EMPTY;
            bit_count_reg     <= 3'd0;
            write_blocked_reg <= 1'b0;
            control_reg       <= CONTROL_RESET;
            chr_low_reg       <= 5'd0;
            chr_high_reg      <= 5'd0;
            prg_reg           <= 5'd0;
            offset_low_reg    <= 18'd0;
            offset_high_reg   <= LAST_BANK_OFFSET;
        end else begin
            shift_value_reg   <= shift_value_next;
            bit_count_reg     <= bit_count_next;
            write_blocked_reg <= write_blocked_next;
            control_reg       <= control_next;
            chr_low_reg       <= chr_low_next;
            chr_high_reg      <= chr_high_next;
            prg_reg           <= prg_next;
            offset_low_reg    <= offset_low_next;
            offset_high_reg   <= offset_high_next;
        end
    end

    assign result.prg_offset_low  = offset_low_next;
    assign result.prg_offset_high = offset_high_next;
    assign result.control_value   = control_next;
    assign result.chr_bank_low    = chr_low_next;
    assign result.chr_bank_high   = chr_high_next;
    assign result.prg_bank        = prg_next;

    `SBSM_ASSERT_NOW(a_count_range, 1'b1, bit_count_reg < BITS_PER_LOAD)
    `SBSM_ASSERT_NOW(a_empty_shift, bit_count_reg == 3'd0, shift_value_reg == SHIFT_EMPTY)
    `SBSM_ASSERT_NEXT(a_unblock, adv && item.op == OP_INSN_DONE, !write_blocked_reg)
    `SBSM_ASSERT_NEXT(a_hold_banks, !adv, $stable(control_reg) && $stable(prg_reg))
    `SBSM_ASSERT_NEXT(a_hold_count, !adv, $stable(bit_count_reg))

endmodule

/* hdl/sbsm_out_stage.sv */
// ----------------------------------------------------------------------------
// sbsm_out_stage
// Result register with valid/ready handshake.
// ----------------------------------------------------------------------------
module sbsm_out_stage
    import sbsm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  sbsm_result_t result,
    output logic         take,
    output logic         m_valid,
    input  logic         m_ready,
    output sbsm_result_t m_result
);

    logic         valid_reg;
    logic         valid_next;
    sbsm_result_t result_reg;

    assign take       = item_valid && (!valid_reg || m_ready);
    assign valid_next = take || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

/* hdl/serial_bank_switch_mapper.sv */
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while m_ready does not hold the result register; mapper state
// is updated as a request moves into the result register, so the next request sees the new state.
// Reset: synchronous, active low; empty pipeline, shift register empty, control 0x06,
// bank registers zero, high PRG offset on the last bank.
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper
// Serially loaded bank-switch register file of a cartridge mapper.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper
    import sbsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [17:0] m_prg_offset_low,
    output logic [17:0] m_prg_offset_high,
    output logic [4:0]  m_control_value,
    output logic [4:0]  m_chr_bank_low,
    output logic [4:0]  m_chr_bank_high,
    output logic [4:0]  m_prg_bank
);

    sbsm_item_t   s_item;
    sbsm_item_t   item;
    logic         item_valid;
    logic         take;
    sbsm_result_t result;
    sbsm_result_t m_result;

    assign s_item.op      = sbsm_op_t'(s_op);
    assign s_item.address = s_address;
    assign s_item.value   = s_value;

    sbsm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sbsm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (take),
        .item    (item),
        .result  (result)
    );

    sbsm_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_prg_offset_low  = m_result.prg_offset_low;
    assign m_prg_offset_high = m_result.prg_offset_high;
    assign m_control_value   = m_result.control_value;
    assign m_chr_bank_low    = m_result.chr_bank_low;
    assign m_chr_bank_high   = m_result.chr_bank_high;
    assign m_prg_bank        = m_result.prg_bank;

endmodule
